>>> design/random_sample_set_macros.svh
// Assertion macros shared by the random sample set RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef RANDOM_SAMPLE_SET_MACROS_SVH
`define RANDOM_SAMPLE_SET_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RSS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define RSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RSS_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define RSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/rss_pkg.sv
// Package for the random sample set: beat types, command and status codes,
// default sizes and the hash multiplier. No dependencies.
package rss_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int MAP_DEPTH_DEF = 128;

    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic        [1:0]  cmd;
        logic signed [31:0] value;
        logic        [15:0] random_word;
    } t_in_item;

    typedef struct packed {
        logic        [1:0]  status;
        logic signed [31:0] sample;
        logic        [6:0]  occupancy;
    } t_out_item;

endpackage

>>> design/random_sample_set.sv
// Random sample set top level: element store and position hash map in
// block RAM, driven by one sequencer. Depends on rss_pkg and the macros header.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one command
//   beat: insert, remove or sample. Output channel (o_out_valid /
//   i_out_stall / o_out_data) returns exactly one result beat per command.
//   One command is in flight at a time. Each hash is a multiply, a
//   reciprocal reduction and one optional correction; each map probe is a
//   registered RAM read and a check. Insert: a hash, probes, a write.
//   Sample: 32-step remainder by the count, then a store read. Remove: a
//   hash, probes, moving the last element, backward-shift deletion that
//   rehashes each entry. Empty sample and unused command: straight to result.
//   The next command is taken the cycle after the result is loaded.
//   Reset: a clearing pass over every map slot empties the map; o_in_stall
//   stays high until it ends. Count resets to zero.
//   A stalled output beat holds; the sequencer waits on it before loading
//   the following result.
`include "random_sample_set_macros.svh"
module random_sample_set #(
    parameter int CAPACITY  = rss_pkg::CAPACITY_DEF,
    parameter int MAP_DEPTH = rss_pkg::MAP_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rss_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rss_pkg::t_out_item  o_out_data
);

    localparam int LIMIT = (CAPACITY < MAP_DEPTH) ? CAPACITY : MAP_DEPTH;
    localparam int SW    = $clog2(MAP_DEPTH);
    localparam int PW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int PRW   = $clog2(MAP_DEPTH + 1);
    localparam int MW    = $clog2(MAP_DEPTH + 1);
    localparam int DW    = (MW > CW) ? MW : CW;
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(MAP_DEPTH));

    typedef struct packed {
        logic          valid;
        logic [31:0]   key;
        logic [PW-1:0] pos;
    } t_map_entry;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_HASH, S_RED_MUL, S_RED_SUB, S_RED_FIX, S_DIV,
        S_FIND_HOME, S_FIND_RD, S_FIND_CHK,
        S_INS_WR, S_LAST_RD, S_LAST_Q, S_LAST_WR, S_POS_WR, S_DEL_RD,
        S_DEL_CHK, S_DEL_HOME, S_DEL_END, S_SMP_RD, S_SMP_WAIT, S_SMP_Q, S_OUT
    } t_state;

    t_state            r_state, r_ret;
    logic [1:0]        r_cmd;
    logic [31:0]       r_key;
    logic [31:0]       r_num;
    logic [63:0]       r_prod;
    logic [31:0]       r_red;
    logic [DW-1:0]     r_rem, r_den;
    logic [4:0]        r_dcnt;
    logic [SW-1:0]     r_slot, r_hole;
    logic [PRW-1:0]    r_probe;
    logic [CW-1:0]     r_count;
    logic [PW-1:0]     r_idx, r_sidx;
    logic [31:0]       r_last;
    logic              r_find_last;
    t_map_entry        r_jent;
    logic [1:0]        r_res_status;
    logic [31:0]       r_res_sample;
    logic              r_ovalid;
    rss_pkg::t_out_item r_out;

    t_map_entry        map_mem [MAP_DEPTH];
    t_map_entry        r_map_q;
    logic [31:0]       store_mem [CAPACITY];
    logic [31:0]       r_store_q;

    logic              map_we;
    logic [SW-1:0]     map_wa;
    t_map_entry        map_wd;
    logic              store_we;
    logic [PW-1:0]     store_wa;
    logic [31:0]       store_wd;

    logic [DW:0]       div_t;
    logic [DW-1:0]     n_rem;
    logic [31:0]       hash_p;
    logic [SW-1:0]     slot_nx, hole_nx, home_k;
    logic              stays;

    always_comb begin
        div_t = {r_rem, r_num[31]};
        if (div_t >= {1'b0, r_den}) begin
            n_rem = DW'(div_t - {1'b0, r_den});
        end else begin
            n_rem = DW'(div_t);
        end
    end

    assign hash_p  = r_key * rss_pkg::HASH_MULT;
    assign slot_nx = (r_slot == SW'(MAP_DEPTH - 1)) ? '0 : r_slot + 1'b1;
    assign hole_nx = (r_hole == SW'(MAP_DEPTH - 1)) ? '0 : r_hole + 1'b1;
    assign home_k  = r_red[SW-1:0];

    always_comb begin
        if (r_hole <= r_slot) begin
            stays = (r_hole < home_k) && (home_k <= r_slot);
        end else begin
            stays = (r_hole < home_k) || (home_k <= r_slot);
        end
    end

    always_comb begin
        map_we = 1'b0;
        map_wa = r_slot;
        map_wd = '0;
        unique case (r_state)
            S_CLEAR: begin
                map_we = 1'b1;
            end
            S_INS_WR: begin
                map_we = 1'b1;
                map_wd = '{valid: 1'b1, key: r_key, pos: PW'(r_count)};
            end
            S_POS_WR: begin
                map_we     = 1'b1;
                map_wd     = r_map_q;
                map_wd.pos = r_idx;
            end
            S_DEL_HOME: begin
                map_we = !stays;
                map_wa = r_hole;
                map_wd = r_jent;
            end
            S_DEL_END: begin
                map_we = 1'b1;
                map_wa = r_hole;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        store_we = 1'b0;
        store_wa = PW'(r_count);
        store_wd = r_key;
        unique case (r_state)
            S_INS_WR: begin
                store_we = 1'b1;
            end
            S_LAST_WR: begin
                store_we = 1'b1;
                store_wa = r_idx;
                store_wd = r_last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        r_map_q <= map_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            store_mem[store_wa] <= store_wd;
        end
        r_store_q <= store_mem[r_sidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_slot   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_ovalid || !i_out_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_slot <= slot_nx;
                    if (r_slot == SW'(MAP_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd        <= i_in_data.cmd;
                        r_key        <= i_in_data.value;
                        r_find_last  <= 1'b0;
                        r_res_status <= rss_pkg::ST_DONE;
                        r_res_sample <= '0;
                        unique case (i_in_data.cmd)
                            rss_pkg::CMD_INSERT, rss_pkg::CMD_REMOVE: begin
                                r_ret   <= S_FIND_HOME;
                                r_state <= S_HASH;
                            end
                            rss_pkg::CMD_SAMPLE: begin
                                if (r_count == '0) begin
                                    r_res_status <= rss_pkg::ST_EMPTY;
                                    r_state      <= S_OUT;
                                end else begin
                                    r_num   <= {16'd0, i_in_data.random_word};
                                    r_den   <= DW'(r_count);
                                    r_rem   <= '0;
                                    r_dcnt  <= '0;
                                    r_ret   <= S_SMP_RD;
                                    r_state <= S_DIV;
                                end
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_HASH: begin
                    r_num   <= hash_p ^ (hash_p >> 16);
                    r_state <= S_RED_MUL;
                end
                S_RED_MUL: begin
                    r_prod  <= {32'd0, r_num} * {32'd0, RECIP};
                    r_state <= S_RED_SUB;
                end
                S_RED_SUB: begin
                    r_red   <= r_num - r_prod[63:32] * 32'(MAP_DEPTH);
                    r_state <= S_RED_FIX;
                end
                S_RED_FIX: begin
                    if (r_red >= 32'(MAP_DEPTH)) begin
                        r_red <= r_red - 32'(MAP_DEPTH);
                    end else begin
                        r_state <= r_ret;
                    end
                end
                S_DIV: begin
                    r_rem  <= n_rem;
                    r_num  <= r_num << 1;
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 5'd31) begin
                        r_state <= r_ret;
                    end
                end
                S_FIND_HOME: begin
                    r_slot  <= home_k;
                    r_probe <= '0;
                    r_state <= S_FIND_RD;
                end
                S_FIND_RD: begin
                    r_state <= S_FIND_CHK;
                end
                S_FIND_CHK: begin
                    if (r_map_q.valid && r_map_q.key == r_key) begin
                        if (r_find_last) begin
                            r_state <= S_POS_WR;
                        end else if (r_cmd == rss_pkg::CMD_INSERT) begin
                            r_res_status <= rss_pkg::ST_PRESENT;
                            r_state      <= S_OUT;
                        end else if (r_count == '0) begin
                            r_res_status <= rss_pkg::ST_PRESENT;
                            r_state      <= S_OUT;
                        end else begin
                            r_hole  <= r_slot;
                            r_idx   <= r_map_q.pos;
                            r_sidx  <= PW'(r_count - 1'b1);
                            r_state <= S_LAST_RD;
                        end
                    end else if (r_map_q.valid && r_probe != PRW'(MAP_DEPTH - 1)) begin
                        r_slot  <= slot_nx;
                        r_probe <= r_probe + 1'b1;
                        r_state <= S_FIND_RD;
                    end else begin
                        if (r_find_last) begin
                            r_slot  <= hole_nx;
                            r_probe <= '0;
                            r_state <= S_DEL_RD;
                        end else if (r_cmd == rss_pkg::CMD_INSERT) begin
                            if (r_count >= CW'(LIMIT)) begin
                                r_res_status <= rss_pkg::ST_FULL;
                                r_state      <= S_OUT;
                            end else begin
                                r_state <= S_INS_WR;
                            end
                        end else begin
                            r_res_status <= rss_pkg::ST_PRESENT;
                            r_state      <= S_OUT;
                        end
                    end
                end
                S_INS_WR: begin
                    r_count <= r_count + 1'b1;
                    r_state <= S_OUT;
                end
                S_LAST_RD: begin
                    r_state <= S_LAST_Q;
                end
                S_LAST_Q: begin
                    r_last  <= r_store_q;
                    r_state <= S_LAST_WR;
                end
                S_LAST_WR: begin
                    r_key       <= r_last;
                    r_find_last <= 1'b1;
                    r_ret       <= S_FIND_HOME;
                    r_state     <= S_HASH;
                end
                S_POS_WR: begin
                    r_slot  <= hole_nx;
                    r_probe <= '0;
                    r_state <= S_DEL_RD;
                end
                S_DEL_RD: begin
                    r_state <= S_DEL_CHK;
                end
                S_DEL_CHK: begin
                    if (!r_map_q.valid) begin
                        r_state <= S_DEL_END;
                    end else begin
                        r_jent  <= r_map_q;
                        r_key   <= r_map_q.key;
                        r_ret   <= S_DEL_HOME;
                        r_state <= S_HASH;
                    end
                end
                S_DEL_HOME: begin
                    if (!stays) begin
                        r_hole <= r_slot;
                    end
                    if (r_probe == PRW'(MAP_DEPTH - 1)) begin
                        r_state <= S_DEL_END;
                    end else begin
                        r_probe <= r_probe + 1'b1;
                        r_slot  <= slot_nx;
                        r_state <= S_DEL_RD;
                    end
                end
                S_DEL_END: begin
                    r_count <= r_count - 1'b1;
                    r_state <= S_OUT;
                end
                S_SMP_RD: begin
                    r_sidx  <= r_rem[PW-1:0];
                    r_state <= S_SMP_WAIT;
                end
                S_SMP_WAIT: begin
                    r_state <= S_SMP_Q;
                end
                S_SMP_Q: begin
                    r_res_sample <= r_store_q;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_out    <= '{status: r_res_status, sample: r_res_sample,
                                      occupancy: 7'(r_count)};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    `RSS_ASSERT_ALWAYS(a_count_limit, i_clk, i_rst_n, r_count <= CW'(LIMIT))
    `RSS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall,
        r_state != S_IDLE)
    `RSS_ASSERT_NEXT(a_out_blocked, i_clk, i_rst_n,
        r_state == S_OUT && r_ovalid && i_out_stall, r_state == S_OUT && r_ovalid)

endmodule

>>> test/random_sample_set_check.sv
// Checker for the random sample set: watches both channels, predicts each
// result beat from its own copy of the set and compares. Depends on rss_pkg.
`timescale 1ns / 100ps
module random_sample_set_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  rss_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  rss_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int LIMIT = (rss_pkg::CAPACITY_DEF < rss_pkg::MAP_DEPTH_DEF) ?
                           rss_pkg::CAPACITY_DEF : rss_pkg::MAP_DEPTH_DEF;

    logic [31:0]        elems [rss_pkg::CAPACITY_DEF];
    int unsigned        count;
    int unsigned        where [logic [31:0]];
    rss_pkg::t_out_item results_due [$];

    function automatic rss_pkg::t_out_item apply_cmd(rss_pkg::t_in_item it);
        rss_pkg::t_out_item r;
        logic [31:0]        v;
        logic [31:0]        last;
        int unsigned        idx;
        r = '0;
        v = it.value;
        case (it.cmd)
            rss_pkg::CMD_INSERT: begin
                if (where.exists(v)) begin
                    r.status = rss_pkg::ST_PRESENT;
                end else if (count >= LIMIT) begin
                    r.status = rss_pkg::ST_FULL;
                end else begin
                    elems[count] = v;
                    where[v] = count;
                    count++;
                end
            end
            rss_pkg::CMD_REMOVE: begin
                if (!where.exists(v) || count == 0) begin
                    r.status = rss_pkg::ST_PRESENT;
                end else begin
                    idx = where[v];
                    last = elems[count - 1];
                    elems[idx] = last;
                    where[last] = idx;
                    where.delete(v);
                    count--;
                end
            end
            rss_pkg::CMD_SAMPLE: begin
                if (count == 0) r.status = rss_pkg::ST_EMPTY;
                else r.sample = elems[32'(it.random_word) % count];
            end
            default: ;
        endcase
        r.occupancy = 7'(count);
        return r;
    endfunction

    assign o_pending = results_due.size();

    always @(posedge i_clk) begin
        rss_pkg::t_out_item want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            count = 0;
            where.delete();
            results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = results_due.pop_front();
                    if (want.status !== i_out_data.status)
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, i_out_data.status);
                    if (want.sample !== i_out_data.sample)
                        $display("%0t: sample expected %h actual %h", $time,
                                 want.sample, i_out_data.sample);
                    if (want.occupancy !== i_out_data.occupancy)
                        $display("%0t: occupancy expected %0d actual %0d", $time,
                                 want.occupancy, i_out_data.occupancy);
                    if (want !== i_out_data) o_fail_count <= o_fail_count + 1;
                end
            end
            if (i_in_valid && !i_in_stall)
                results_due.push_back(apply_cmd(i_in_data));
        end
    end
endmodule

>>> test/random_sample_set_test.sv
// Testbench top for the random sample set: drives directed and random command
// beats with random idling, gives the verdict. Depends on rss_pkg, the design and the checker.
`timescale 1ns / 100ps
module random_sample_set_test;

    localparam int N_RANDOM = 750;
    localparam int WATCHDOG = 60000;

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               in_stall;
    rss_pkg::t_in_item  in_data;
    logic               out_valid;
    logic               out_stall;
    rss_pkg::t_out_item out_data;
    int                 fail_count;
    int                 pending;
    int                 phase;
    int                 idle_cycles;

    rss_pkg::t_in_item cmds [$];
    logic [31:0]       pool [96];
    int                n_directed;

    random_sample_set uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data)
    );

    random_sample_set_check check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic rss_pkg::t_in_item mk(logic [1:0] c, logic [31:0] v,
                                             logic [15:0] r);
        rss_pkg::t_in_item it;
        it.cmd = c;
        it.value = v;
        it.random_word = r;
        return it;
    endfunction

    function automatic logic [31:0] rand_val(int k);
        if ($urandom_range(0, 19) == 0) return $urandom;
        return pool[$urandom_range(0, k - 1)];
    endfunction

    task automatic build_stimulus();
        int kind;
        int len;
        logic [1:0] c;
        cmds.push_back(mk(rss_pkg::CMD_SAMPLE, 32'h0, 16'hFFFF));
        cmds.push_back(mk(rss_pkg::CMD_REMOVE, 32'h5, 16'h0));
        cmds.push_back(mk(rss_pkg::CMD_INSERT, 32'h8000_0000, 16'h0));
        cmds.push_back(mk(rss_pkg::CMD_INSERT, 32'h7FFF_FFFF, 16'hFFFF));
        cmds.push_back(mk(rss_pkg::CMD_INSERT, 32'h0, 16'h0));
        cmds.push_back(mk(rss_pkg::CMD_INSERT, 32'hFFFF_FFFF, 16'h0));
        cmds.push_back(mk(rss_pkg::CMD_INSERT, 32'h0, 16'h0));
        cmds.push_back(mk(rss_pkg::CMD_SAMPLE, 32'h0, 16'h0));
        cmds.push_back(mk(rss_pkg::CMD_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF));
        cmds.push_back(mk(rss_pkg::CMD_SAMPLE, 32'h0, 16'h0003));
        cmds.push_back(mk(rss_pkg::CMD_NONE, 32'hFFFF_FFFF, 16'hFFFF));
        cmds.push_back(mk(rss_pkg::CMD_REMOVE, 32'h1234_5678, 16'h0));
        cmds.push_back(mk(rss_pkg::CMD_REMOVE, 32'h8000_0000, 16'h0));
        cmds.push_back(mk(rss_pkg::CMD_SAMPLE, 32'h0, 16'h0000));
        cmds.push_back(mk(rss_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 16'h0));
        cmds.push_back(mk(rss_pkg::CMD_REMOVE, 32'h7FFF_FFFF, 16'h0));
        cmds.push_back(mk(rss_pkg::CMD_REMOVE, 32'h0, 16'h0));
        cmds.push_back(mk(rss_pkg::CMD_REMOVE, 32'h0, 16'h0));
        cmds.push_back(mk(rss_pkg::CMD_SAMPLE, 32'h0, 16'h1));
        n_directed = cmds.size();
        // Random part: fill, churn and drain bursts over a small value pool
        foreach (pool[i]) pool[i] = $urandom;
        while (cmds.size() < n_directed + N_RANDOM) begin
            if ($urandom_range(0, 3) == 0)
                foreach (pool[i]) pool[i] = $urandom;
            kind = $urandom_range(0, 2);
            len = (kind == 0) ? $urandom_range(40, 80) : $urandom_range(10, 40);
            repeat (len) begin
                case (kind)
                    0: c = ($urandom_range(0, 5) == 0) ? rss_pkg::CMD_SAMPLE
                                                       : rss_pkg::CMD_INSERT;
                    1: c = 2'($urandom_range(0, 3));
                    default: c = ($urandom_range(0, 4) == 0) ? rss_pkg::CMD_SAMPLE
                                                             : rss_pkg::CMD_REMOVE;
                endcase
                if ($urandom_range(0, 29) == 0) c = rss_pkg::CMD_NONE;
                cmds.push_back(mk(c, rand_val(kind == 0 ? 96 : 72), 16'($urandom)));
            end
        end
    endtask

    function automatic logic pick_idle(int pct_sender, int pct_recv, logic sender);
        int pct;
        pct = sender ? pct_sender : pct_recv;
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic idle_now(logic sender);
        case (phase)
            0: return pick_idle(25, 75, sender);
            1: return pick_idle(75, 25, sender);
            default: return 1'b0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) out_stall <= 1'b0;
        else out_stall <= idle_now(1'b0);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("** random_sample_set: FAILED **");
            $finish;
        end
    end

    initial begin
        int sent;
        int total;
        in_valid = 1'b0;
        in_data = '0;
        phase = 0;
        i_rst_n = 1'b0;
        build_stimulus();
        total = cmds.size();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sent = 0;
        while (sent < total) begin
            @(posedge i_clk);
            if (in_valid && !in_stall) begin
                sent++;
                if (sent == n_directed) begin
                    in_valid <= 1'b0;
                    // hold off until the set has answered everything so far
                    do @(posedge i_clk); while (pending != 0);
                end
            end
            phase = (sent < n_directed + N_RANDOM / 3) ? 0 :
                    (sent < n_directed + 2 * N_RANDOM / 3) ? 1 : 2;
            if (!in_valid || !in_stall) begin
                if (sent < total && !idle_now(1'b1)) begin
                    in_valid <= 1'b1;
                    in_data <= cmds[sent];
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("** random_sample_set: PASSED **");
        else
            $display("** random_sample_set: FAILED **");
        $finish;
    end
endmodule
